/* hdl/candle_indicator_tracker_defines.svh */
// Assertion macros used by the engine RTL file.
`ifndef CANDLE_INDICATOR_TRACKER_DEFINES_SVH
`define CANDLE_INDICATOR_TRACKER_DEFINES_SVH

// Checked at every clock edge outside reset.
`define CIT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CIT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hdl/cit_pkg.sv */
`default_nettype none
package cit_pkg;
   localparam int RangeWindow = 14;
   localparam int CloseDepth  = 20;
   localparam int RangeIdxW   = $clog2(RangeWindow);
   localparam int RangeCntW   = $clog2(RangeWindow + 1);
   localparam int CloseIdxW   = $clog2(CloseDepth);
   localparam int CloseCntW   = $clog2(CloseDepth + 1);
   localparam int FracBits    = 16;
   localparam int NumW        = 64;
   localparam int DenW        = 32;
   localparam int StepW       = $clog2(NumW);

   localparam logic [1:0] RegPeriod = 2'd0;
   localparam logic [1:0] RegLag    = 2'd1;
   localparam logic [1:0] RegBrick  = 2'd2;

   localparam logic [26:0] PeriodReset = 27'd300000;
   localparam logic [4:0]  LagReset    = 5'd12;
   localparam logic [31:0] BrickReset  = 32'd1;

   localparam logic [7:0] FastMul = 8'd49;
   localparam logic [7:0] FastDiv = 8'd51;
   localparam logic [7:0] SlowMul = 8'd199;
   localparam logic [7:0] SlowDiv = 8'd201;

   // Reciprocals ceil(2^32 / divisor), exact for partial remainders below 2^24.
   localparam logic [26:0] FastRecip = 27'd84215046;
   localparam logic [26:0] SlowRecip = 27'd21367997;

   localparam logic [47:0] SMax48 = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] SMin48 = 48'h8000_0000_0000;

   typedef struct packed {
      logic [31:0] price;
      logic [47:0] time_ms;
   } item_type;

   typedef struct packed {
      logic [26:0] period;
      logic [4:0]  lag;
      logic [31:0] brick;
   } cfg_type;

   typedef struct packed {
      logic            start;
      logic [NumW-1:0] num;
      logic [DenW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [NumW-1:0] quot;
      logic [DenW-1:0] rem;
   } div_rsp_type;
endpackage
`default_nettype wire

/* hdl/cit_req_if.sv */
`default_nettype none
interface cit_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] price;
   logic [47:0] time_ms;
   modport source(output valid, price, time_ms, input ready);
   modport sink(input valid, price, time_ms, output ready);
endinterface
`default_nettype wire

/* hdl/cit_rsp_if.sv */
`default_nettype none
interface cit_rsp_if;
   logic               valid;
   logic               ready;
   logic [47:0]        ema_fast;
   logic [47:0]        ema_slow;
   logic [47:0]        avg_true_range;
   logic signed [47:0] momentum;
   logic               ready_res;
   logic               candle_closed;
   modport source(output valid, ema_fast, ema_slow, avg_true_range, momentum, ready_res,
                  candle_closed, input ready);
   modport sink(input valid, ema_fast, ema_slow, avg_true_range, momentum, ready_res,
                candle_closed, output ready);
endinterface
`default_nettype wire

/* hdl/cit_csr_if.sv */
`default_nettype none
interface cit_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  addr;
   logic [31:0] data;
   modport source(output valid, addr, data, input ready);
   modport sink(input valid, addr, data, output ready);
endinterface
`default_nettype wire

/* hdl/cit_div.sv */
`default_nettype none
module cit_div (
   input  wire                  clock,
   input  wire                  reset,
   input  cit_pkg::div_req_type div_req,
   output cit_pkg::div_rsp_type div_rsp
);
   logic                        busy_ff;
   logic                        done_ff;
   logic [cit_pkg::StepW-1:0]   step_ff;
   logic [cit_pkg::NumW-1:0]    num_ff;
   logic [cit_pkg::DenW-1:0]    rem_ff;
   logic [cit_pkg::DenW-1:0]    den_ff;
   logic [cit_pkg::DenW:0]      trial;
   logic                        fits;

   assign trial = {rem_ff, num_ff[cit_pkg::NumW-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == cit_pkg::StepW'(cit_pkg::NumW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         num_ff <= div_req.num;
         den_ff <= div_req.den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[cit_pkg::NumW-2:0], fits};
         rem_ff <= fits ? cit_pkg::DenW'(trial - {1'b0, den_ff})
                        : cit_pkg::DenW'(trial);
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = num_ff;
   assign div_rsp.rem  = rem_ff;
endmodule
`default_nettype wire

/* hdl/cit_front.sv */
`default_nettype none
module cit_front (
   input  wire               clock,
   input  wire               reset,
   cit_req_if.sink           req_chan,
   output logic              item_valid,
   output cit_pkg::item_type item,
   input  wire               item_pop
);
   cit_pkg::item_type fifo_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              push;
   logic              pop;

   assign req_chan.ready = count_ff != 2'd2;
   assign push       = req_chan.valid && req_chan.ready;
   assign pop        = item_pop && item_valid;
   assign item_valid = count_ff != 2'd0;
   assign item       = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff].price   <= req_chan.price;
         fifo_ff[wr_ptr_ff].time_ms <= req_chan.time_ms;
      end
   end
endmodule
`default_nettype wire

/* hdl/cit_engine.sv */
`default_nettype none
`include "candle_indicator_tracker_defines.svh"
module cit_engine (
   input  wire               clock,
   input  wire               reset,
   input  wire               item_valid,
   input  cit_pkg::item_type item,
   output logic              item_pop,
   input  cit_pkg::cfg_type  cfg,
   cit_rsp_if.source         rsp_chan
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MOD    = 4'd1;
   localparam logic [3:0] S_DECIDE = 4'd2;
   localparam logic [3:0] S_MULF   = 4'd3;
   localparam logic [3:0] S_DIVF   = 4'd4;
   localparam logic [3:0] S_WF     = 4'd5;
   localparam logic [3:0] S_MULS   = 4'd6;
   localparam logic [3:0] S_DIVS   = 4'd7;
   localparam logic [3:0] S_WS     = 4'd8;
   localparam logic [3:0] S_RANGE  = 4'd9;
   localparam logic [3:0] S_ATRD   = 4'd10;
   localparam logic [3:0] S_ATRW   = 4'd11;
   localparam logic [3:0] S_OPEN   = 4'd12;
   localparam logic [3:0] S_MOM    = 4'd13;
   localparam logic [3:0] S_MOMW   = 4'd14;
   localparam logic [3:0] S_OUT    = 4'd15;

   localparam logic [cit_pkg::RangeCntW-1:0] RangeTop =
      cit_pkg::RangeCntW'(cit_pkg::RangeWindow);
   localparam logic [cit_pkg::CloseCntW-1:0] CloseTop =
      cit_pkg::CloseCntW'(cit_pkg::CloseDepth);
   localparam logic [cit_pkg::CloseCntW-1:0] CloseOne = cit_pkg::CloseCntW'(1);

   logic [3:0]                      state_ff;
   logic [3:0]                      state_in;
   cit_pkg::div_req_type            div_req_ff;
   cit_pkg::div_rsp_type            div_rsp;
   logic                            div_start;

   logic [31:0]                     price_ff;
   logic [47:0]                     time_ff;
   logic [47:0]                     pstart_ff;
   logic                            closed_ff;
   logic [63:0]                     prod_ff;
   logic                            neg_ff;

   logic [63:0]                     cnum_ff;
   logic [63:0]                     cquot_ff;
   logic [7:0]                      crem_ff;
   logic [15:0]                     cqd_ff;
   logic [2:0]                      cstep_ff;
   logic                            cslow_ff;
   logic [7:0]                      cden;
   logic [26:0]                     crecip;
   logic [23:0]                     cpart;
   logic [50:0]                     cprod;
   logic [23:0]                     cleft;

   logic                            active_ff;
   logic [47:0]                     start_ff;
   logic [31:0]                     high_ff;
   logic [31:0]                     low_ff;
   logic [31:0]                     last_ff;
   logic                            seeded_ff;
   logic [47:0]                     fast_ff;
   logic [47:0]                     slow_ff;
   logic [31:0]                     prev_ff;
   logic [31:0]                     range_ring [cit_pkg::RangeWindow];
   logic [cit_pkg::RangeIdxW-1:0]   range_head_ff;
   logic [cit_pkg::RangeCntW-1:0]   range_count_ff;
   logic [35:0]                     range_sum_ff;
   logic [47:0]                     range_mean_ff;
   logic [31:0]                     close_ring [cit_pkg::CloseDepth];
   logic [cit_pkg::CloseIdxW-1:0]   close_head_ff;
   logic [cit_pkg::CloseCntW-1:0]   close_count_ff;

   logic                            rsp_valid_ff;
   logic [47:0]                     rsp_fast_ff;
   logic [47:0]                     rsp_slow_ff;
   logic [47:0]                     rsp_atr_ff;
   logic [47:0]                     rsp_mom_ff;
   logic [47:0]                     mom_ff;
   logic                            rsp_seeded_ff;
   logic                            rsp_closed_ff;

   logic [26:0]                     period_eff;
   logic [31:0]                     brick_eff;
   logic                            new_candle;
   logic [31:0]                     tr_hl;
   logic [31:0]                     tr_hp;
   logic [31:0]                     tr_lp;
   logic [31:0]                     tr_a;
   logic [31:0]                     tr;
   logic                            range_full;
   logic                            lag_ok;
   logic [cit_pkg::CloseIdxW:0]     lag_idx_wide;
   logic [cit_pkg::CloseIdxW-1:0]   lag_idx;
   logic [31:0]                     old_close;
   logic [31:0]                     mom_diff;
   logic [47:0]                     mag;
   logic                            out_free;

   cit_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req_ff),
      .div_rsp(div_rsp)
   );

   assign period_eff = (cfg.period == '0) ? 27'd1 : cfg.period;
   assign brick_eff  = (cfg.brick == '0) ? 32'd1 : cfg.brick;
   assign new_candle = !active_ff || (pstart_ff > start_ff);

   assign tr_hl = high_ff - low_ff;
   assign tr_hp = (high_ff >= prev_ff) ? high_ff - prev_ff : prev_ff - high_ff;
   assign tr_lp = (low_ff >= prev_ff) ? low_ff - prev_ff : prev_ff - low_ff;
   assign tr_a  = (tr_hp > tr_hl) ? tr_hp : tr_hl;
   assign tr    = (tr_lp > tr_a) ? tr_lp : tr_a;
   assign range_full = range_count_ff == RangeTop;

   // The EMA divisions by a constant run as four 16-bit digits, each taking a reciprocal
   // multiply for the digit and a multiply-subtract for the remainder.
   assign cden   = cslow_ff ? cit_pkg::SlowDiv : cit_pkg::FastDiv;
   assign crecip = cslow_ff ? cit_pkg::SlowRecip : cit_pkg::FastRecip;
   assign cpart  = {crem_ff, cnum_ff[63:48]};
   assign cprod  = 51'(cpart) * 51'(crecip);
   assign cleft  = cpart - 24'(cqd_ff) * 24'(cden);

   assign lag_ok = (cfg.lag != 5'd0) &&
                   (cit_pkg::CloseCntW'(cfg.lag) <= close_count_ff);
   assign lag_idx_wide = ({1'b0, close_head_ff} >= (cit_pkg::CloseIdxW + 1)'(cfg.lag))
      ? {1'b0, close_head_ff} - (cit_pkg::CloseIdxW + 1)'(cfg.lag)
      : {1'b0, close_head_ff} + (cit_pkg::CloseIdxW + 1)'(cit_pkg::CloseDepth)
        - (cit_pkg::CloseIdxW + 1)'(cfg.lag);
   assign lag_idx   = lag_idx_wide[cit_pkg::CloseIdxW-1:0];
   assign old_close = close_ring[lag_idx];
   assign mom_diff  = (price_ff >= old_close) ? price_ff - old_close : old_close - price_ff;
   assign mag       = div_rsp.quot[47:0];
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign item_pop  = (state_ff == S_IDLE) && item_valid;
   assign div_start = ((state_ff == S_IDLE) && item_valid) || (state_ff == S_ATRD) ||
                      ((state_ff == S_MOM) && lag_ok);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (item_valid) state_in = S_MOD;
         S_MOD:    if (div_rsp.done) state_in = S_DECIDE;
         S_DECIDE: begin
            if (!new_candle) state_in = S_MOM;
            else if (active_ff && seeded_ff) state_in = S_MULF;
            else state_in = S_OPEN;
         end
         S_MULF:   state_in = S_DIVF;
         S_DIVF:   state_in = S_WF;
         S_WF:     if (cstep_ff == 3'd7) state_in = S_MULS;
         S_MULS:   state_in = S_DIVS;
         S_DIVS:   state_in = S_WS;
         S_WS:     if (cstep_ff == 3'd7) state_in = S_RANGE;
         S_RANGE:  state_in = S_ATRD;
         S_ATRD:   state_in = S_ATRW;
         S_ATRW:   if (div_rsp.done) state_in = S_OPEN;
         S_OPEN:   state_in = S_MOM;
         S_MOM:    state_in = lag_ok ? S_MOMW : S_OUT;
         S_MOMW:   if (div_rsp.done) state_in = S_OUT;
         S_OUT:    if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         div_req_ff.start <= 1'b0;
         active_ff        <= 1'b0;
         start_ff         <= '0;
         high_ff          <= '0;
         low_ff           <= '0;
         last_ff          <= '0;
         seeded_ff        <= 1'b0;
         fast_ff          <= '0;
         slow_ff          <= '0;
         prev_ff          <= '0;
         range_head_ff    <= '0;
         range_count_ff   <= '0;
         range_sum_ff     <= '0;
         range_mean_ff    <= '0;
         close_head_ff    <= '0;
         close_count_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         div_req_ff.start <= div_start;
         if ((state_ff == S_OUT) && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  div_req_ff.num   <= 64'(item.time_ms);
                  div_req_ff.den   <= 32'(period_eff);
               end
            end
            S_DECIDE: begin
               if (new_candle && active_ff) begin
                  close_ring[close_head_ff] <= last_ff;
                  close_head_ff <= (close_head_ff ==
                                    cit_pkg::CloseIdxW'(cit_pkg::CloseDepth - 1))
                                   ? '0 : close_head_ff + 1'b1;
                  if (close_count_ff != CloseTop)
                     close_count_ff <= close_count_ff + 1'b1;
                  if (!seeded_ff) begin
                     fast_ff       <= {last_ff, 16'b0};
                     slow_ff       <= {last_ff, 16'b0};
                     prev_ff       <= last_ff;
                     range_mean_ff <= '0;
                     seeded_ff     <= 1'b1;
                  end
               end else if (!new_candle) begin
                  if (price_ff > high_ff) high_ff <= price_ff;
                  if (price_ff < low_ff) low_ff <= price_ff;
                  last_ff <= price_ff;
               end
            end
            S_MULS: fast_ff <= cquot_ff[47:0];
            S_RANGE: begin
               slow_ff <= cquot_ff[47:0];
               range_ring[range_head_ff] <= tr;
               range_head_ff <= (range_head_ff ==
                                 cit_pkg::RangeIdxW'(cit_pkg::RangeWindow - 1))
                                ? '0 : range_head_ff + 1'b1;
               if (range_full)
                  range_sum_ff <= range_sum_ff - 36'(range_ring[range_head_ff]) + 36'(tr);
               else begin
                  range_sum_ff   <= range_sum_ff + 36'(tr);
                  range_count_ff <= range_count_ff + 1'b1;
               end
               prev_ff <= last_ff;
            end
            S_ATRD: begin
               div_req_ff.num   <= {12'b0, range_sum_ff, 16'b0};
               div_req_ff.den   <= 32'(range_count_ff);
            end
            S_ATRW: if (div_rsp.done) range_mean_ff <= div_rsp.quot[47:0];
            S_OPEN: begin
               high_ff   <= price_ff;
               low_ff    <= price_ff;
               last_ff   <= price_ff;
               start_ff  <= pstart_ff;
               active_ff <= 1'b1;
            end
            S_MOM: begin
               if (lag_ok) begin
                  div_req_ff.num   <= {16'b0, mom_diff, 16'b0};
                  div_req_ff.den   <= brick_eff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            price_ff  <= item.price;
            time_ff   <= item.time_ms;
            closed_ff <= 1'b0;
         end
         S_MOD: if (div_rsp.done) pstart_ff <= time_ff - 48'(div_rsp.rem[26:0]);
         S_DECIDE: closed_ff <= new_candle && active_ff;
         S_MULF: prod_ff <= 64'(fast_ff) * 64'(cit_pkg::FastMul) + (64'(last_ff) << 17);
         S_DIVF: begin
            cnum_ff  <= prod_ff;
            crem_ff  <= '0;
            cstep_ff <= '0;
            cslow_ff <= 1'b0;
         end
         S_MULS: prod_ff <= 64'(slow_ff) * 64'(cit_pkg::SlowMul) + (64'(last_ff) << 17);
         S_DIVS: begin
            cnum_ff  <= prod_ff;
            crem_ff  <= '0;
            cstep_ff <= '0;
            cslow_ff <= 1'b1;
         end
         S_WF, S_WS: begin
            cstep_ff <= cstep_ff + 1'b1;
            if (!cstep_ff[0]) cqd_ff <= cprod[47:32];
            else begin
               crem_ff  <= cleft[7:0];
               cnum_ff  <= {cnum_ff[47:0], 16'b0};
               cquot_ff <= {cquot_ff[47:0], cqd_ff};
            end
         end
         S_MOM: begin
            neg_ff <= price_ff < old_close;
            if (!lag_ok) mom_ff <= '0;
         end
         S_MOMW: begin
            if (div_rsp.done) begin
               if (!neg_ff) mom_ff <= (mag > cit_pkg::SMax48) ? cit_pkg::SMax48 : mag;
               else mom_ff <= (mag > cit_pkg::SMin48) ? cit_pkg::SMin48 : 48'(-mag);
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_fast_ff   <= fast_ff;
               rsp_slow_ff   <= slow_ff;
               rsp_atr_ff    <= range_mean_ff;
               rsp_mom_ff    <= mom_ff;
               rsp_seeded_ff <= seeded_ff;
               rsp_closed_ff <= closed_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.ema_fast       = rsp_fast_ff;
   assign rsp_chan.ema_slow       = rsp_slow_ff;
   assign rsp_chan.avg_true_range = rsp_atr_ff;
   assign rsp_chan.momentum       = $signed(rsp_mom_ff);
   assign rsp_chan.ready_res      = rsp_seeded_ff;
   assign rsp_chan.candle_closed  = rsp_closed_ff;

   `CIT_ASSERT(a_range_bound, range_count_ff <= RangeTop, "range count overflow")
   `CIT_ASSERT(a_close_bound, close_count_ff <= CloseTop, "close count overflow")
   `CIT_ASSERT(a_seed_first, $rose(seeded_ff) |-> close_count_ff == CloseOne, "late seeding")
   `CIT_ASSERT(a_div_idle, div_req_ff.start |=> !div_rsp.done, "divider done after start")
endmodule
`default_nettype wire

/* hdl/candle_indicator_tracker.sv */
// A tick that stays in its candle takes two passes through the shared radix-2 divider (candle
// bucket, momentum quotient); the momentum pass is skipped, momentum being zero, when the lag is
// zero or exceeds the stored closes. Opening a candle adds an S_OPEN step; closing a seeded
// candle adds a divider pass for the ATR mean and two EMA divisions by a constant.
// Ticks run one at a time, each starting once the last result enters the result register, which
// waits while the output is held; a two-entry input queue takes ticks while a result waits.
// Synchronous reset clears candle, EMA, ATR and ring-count state and restores register defaults.
`default_nettype none
module candle_indicator_tracker (
   input wire       clock,
   input wire       reset,
   cit_req_if.sink  req_chan,
   cit_rsp_if.source rsp_chan,
   cit_csr_if.sink  csr_chan
);
   cit_pkg::cfg_type  cfg_ff;
   cit_pkg::item_type item;
   logic              item_valid;
   logic              item_pop;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period <= cit_pkg::PeriodReset;
         cfg_ff.lag    <= cit_pkg::LagReset;
         cfg_ff.brick  <= cit_pkg::BrickReset;
      end else if (csr_chan.valid) begin
         case (csr_chan.addr)
            cit_pkg::RegPeriod: cfg_ff.period <= csr_chan.data[26:0];
            cit_pkg::RegLag:    cfg_ff.lag    <= csr_chan.data[4:0];
            cit_pkg::RegBrick:  cfg_ff.brick  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   cit_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .item_valid(item_valid),
      .item      (item),
      .item_pop  (item_pop)
   );

   cit_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .item_valid(item_valid),
      .item      (item),
      .item_pop  (item_pop),
      .cfg       (cfg_ff),
      .rsp_chan  (rsp_chan)
   );
endmodule
`default_nettype wire
